// ===== hw/rtl/tss_pkg.sv =====
// Shared widths, control types, reciprocal tables and lattice/blend helpers.
package tss_pkg;

    localparam int COORD_W     = 16;
    localparam int COLOR_W     = 24;
    localparam int CHAN_W      = 8;
    localparam int SUB_W       = 3;
    localparam int MAX_SUBDIV  = 7;
    localparam int NT_W        = 4;
    localparam int NT_MAX      = MAX_SUBDIV + 1;
    localparam int IDX_W       = 3;
    localparam int WT_W        = 5;
    localparam int DIV_W       = 24;
    localparam int DEN_W       = 6;
    localparam int LANES       = 9;
    localparam int COORD_LANES = 6;
    localparam int CNUM_W      = COORD_W + NT_W;
    localparam int CSUM_W      = 14;

    typedef struct packed {
        logic ld_a;
        logic ld_b;
    } div_ctl_t;

    // floor(2^24 / (2*nt))
    function automatic logic [DIV_W-1:0] coord_recip(input logic [NT_W-1:0] nt);
        logic [DIV_W-1:0] m;
        begin
            unique case (nt)
                4'd1:    m = 24'd8388608;
                4'd2:    m = 24'd4194304;
                4'd3:    m = 24'd2796202;
                4'd4:    m = 24'd2097152;
                4'd5:    m = 24'd1677721;
                4'd6:    m = 24'd1398101;
                4'd7:    m = 24'd1198372;
                4'd8:    m = 24'd1048576;
                default: m = '0;
            endcase
            return m;
        end
    endfunction

    // floor(2^24 / (6*nt))
    function automatic logic [DIV_W-1:0] color_recip(input logic [NT_W-1:0] nt);
        logic [DIV_W-1:0] m;
        begin
            unique case (nt)
                4'd1:    m = 24'd2796202;
                4'd2:    m = 24'd1398101;
                4'd3:    m = 24'd932067;
                4'd4:    m = 24'd699050;
                4'd5:    m = 24'd559240;
                4'd6:    m = 24'd466033;
                4'd7:    m = 24'd399457;
                4'd8:    m = 24'd349525;
                default: m = '0;
            endcase
            return m;
        end
    endfunction

    // Biased dividend 2*num + nt + 2nt*2^19; quotient low bits equal the rounded coordinate.
    function automatic logic [DIV_W-1:0] lat_x(
        input logic signed [COORD_W-1:0] a,
        input logic signed [COORD_W-1:0] b,
        input logic signed [COORD_W-1:0] c,
        input logic [NT_W-1:0]           i,
        input logic [NT_W-1:0]           j,
        input logic [NT_W-1:0]           nt
    );
        logic [NT_W-1:0]          wa;
        logic signed [CNUM_W-1:0] num;
        logic signed [DIV_W:0]    t;
        begin
            wa  = nt - i - j;
            num = CNUM_W'(a) * CNUM_W'($signed({1'b0, wa}))
                + CNUM_W'(b) * CNUM_W'($signed({1'b0, i}))
                + CNUM_W'(c) * CNUM_W'($signed({1'b0, j}));
            t   = ((DIV_W + 1)'(num) <<< 1)
                + $signed({21'd0, nt})
                + $signed({1'b0, nt, 20'd0});
            return t[DIV_W-1:0];
        end
    endfunction

    // Dividend 2*num + 3nt for a color channel.
    function automatic logic [DIV_W-1:0] col_x(
        input logic [CHAN_W-1:0] ca,
        input logic [CHAN_W-1:0] cb,
        input logic [CHAN_W-1:0] cc,
        input logic [WT_W-1:0]   wa,
        input logic [WT_W-1:0]   wb,
        input logic [WT_W-1:0]   wc,
        input logic [NT_W-1:0]   nt
    );
        logic [CSUM_W-1:0] s;
        logic [CSUM_W:0]   t;
        begin
            s = CSUM_W'(wa) * CSUM_W'(ca) + CSUM_W'(wb) * CSUM_W'(cb)
              + CSUM_W'(wc) * CSUM_W'(cc);
            t = {s, 1'b0} + (CSUM_W + 1)'(nt) * (CSUM_W + 1)'(3);
            return DIV_W'(t);
        end
    endfunction

endpackage

// ===== hw/rtl/tss_div.sv =====
// Two-stage divider by a small constant: reciprocal multiply, then one-step correction.
module tss_div (
    input  logic                        clk,
    input  tss_pkg::div_ctl_t           ctl,
    input  logic [tss_pkg::DIV_W-1:0]   x,
    input  logic [tss_pkg::DIV_W-1:0]   m,
    input  logic [tss_pkg::DEN_W-1:0]   d,
    output logic [tss_pkg::DIV_W-1:0]   q
);
    import tss_pkg::*;

    logic [2*DIV_W-1:0] full;
    logic [DIV_W-1:0]   x_a_reg;
    logic [DEN_W-1:0]   d_a_reg;
    logic [DIV_W-1:0]   q0_a_reg;
    logic [DIV_W-1:0]   q0_next;
    logic [DIV_W-1:0]   back;
    logic [DIV_W-1:0]   rem;
    logic [DIV_W-1:0]   q_b_reg;
    logic [DIV_W-1:0]   q_b_next;

    always_comb
    begin
        full    = {{DIV_W{1'b0}}, x} * {{DIV_W{1'b0}}, m};
        q0_next = full[2*DIV_W-1:DIV_W];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.ld_a)
        begin
            x_a_reg  <= x;
            d_a_reg  <= d;
            q0_a_reg <= q0_next;
        end
    end

    always_comb
    begin
        back = q0_a_reg * {{(DIV_W - DEN_W){1'b0}}, d_a_reg};
        rem  = x_a_reg - back;
        if (rem >= {{(DIV_W - DEN_W){1'b0}}, d_a_reg})
            q_b_next = q0_a_reg + 1'b1;
        else
            q_b_next = q0_a_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.ld_b)
            q_b_reg <= q_b_next;
    end

    assign q = q_b_reg;

endmodule

// ===== hw/rtl/triangle_subdivision_shader.sv =====
// Top level: chip sequencer feeding a three-stage lattice/color pipeline.
// Throughput: one chip per cycle from the sequencer unless stage 1 stalls; a triangle has
// (s+1)^2 chips, s = subdivisions; the next request is taken in the cycle of the last chip.
// Reset clears the subdivision register (0), the sequencer and all stage valids.
module triangle_subdivision_shader (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tss_pkg::SUB_W-1:0]           subdivisions,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [tss_pkg::COORD_W-1:0]  ax,
    input  logic signed [tss_pkg::COORD_W-1:0]  ay,
    input  logic signed [tss_pkg::COORD_W-1:0]  bx,
    input  logic signed [tss_pkg::COORD_W-1:0]  by,
    input  logic signed [tss_pkg::COORD_W-1:0]  cx,
    input  logic signed [tss_pkg::COORD_W-1:0]  cy,
    input  logic [tss_pkg::COLOR_W-1:0]         a_color,
    input  logic [tss_pkg::COLOR_W-1:0]         b_color,
    input  logic [tss_pkg::COLOR_W-1:0]         c_color,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [tss_pkg::COORD_W-1:0]  p0x,
    output logic signed [tss_pkg::COORD_W-1:0]  p0y,
    output logic signed [tss_pkg::COORD_W-1:0]  p1x,
    output logic signed [tss_pkg::COORD_W-1:0]  p1y,
    output logic signed [tss_pkg::COORD_W-1:0]  p2x,
    output logic signed [tss_pkg::COORD_W-1:0]  p2y,
    output logic [tss_pkg::CHAN_W-1:0]          fill_red,
    output logic [tss_pkg::CHAN_W-1:0]          fill_green,
    output logic [tss_pkg::CHAN_W-1:0]          fill_blue,
    output logic                                last_chip
);
    import tss_pkg::*;

    logic [SUB_W-1:0]          subdiv_reg;

    // chip sequencer
    logic                      gv_reg,   gv_next;
    logic [IDX_W-1:0]          ib_reg,   ib_next;
    logic [IDX_W-1:0]          ic_reg,   ic_next;
    logic                      down_reg, down_next;
    logic [NT_W-1:0]           nt_reg;
    logic signed [COORD_W-1:0] ax_reg, ay_reg, bx_reg, by_reg, cx_reg, cy_reg;
    logic [COLOR_W-1:0]        ac_reg, bc_reg, cc_reg;
    logic                      accept;
    logic                      issue;
    logic                      chip_last;

    // pipeline control
    logic                      v1_reg, v2_reg, v3_reg;
    logic                      rdy1, rdy2, rdy3;
    logic                      last1_reg, last2_reg, last3_reg;
    div_ctl_t                  dctl;

    // stage 1 payload
    logic [NT_W-1:0]           pi [3];
    logic [NT_W-1:0]           pj [3];
    logic [5:0]                rcnt;
    logic [WT_W-1:0]           wa, wb, wc;
    logic [DIV_W-1:0]          x1_next [LANES];
    logic [DIV_W-1:0]          x1_reg  [LANES];
    logic [DIV_W-1:0]          mco1_reg, mcl1_reg;
    logic [DEN_W-1:0]          dco1_reg, dcl1_reg;
    logic [DIV_W-1:0]          q [LANES];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            subdiv_reg <= '0;
        else if (cfg_valid)
            subdiv_reg <= subdivisions;
    end

    assign chip_last = ((NT_W'(ic_reg) + 1'b1) == nt_reg);
    assign issue     = gv_reg && rdy1;
    assign in_ready  = !gv_reg || (issue && chip_last);
    assign accept    = in_valid && in_ready;

    always_comb
    begin
        gv_next   = gv_reg;
        ib_next   = ib_reg;
        ic_next   = ic_reg;
        down_next = down_reg;
        if (accept)
        begin
            gv_next   = 1'b1;
            ib_next   = '0;
            ic_next   = '0;
            down_next = 1'b0;
        end
        else if (issue)
        begin
            if (chip_last)
                gv_next = 1'b0;
            else if (down_reg)
            begin
                down_next = 1'b0;
                ib_next   = ib_reg + 1'b1;
            end
            else if ((NT_W'(ib_reg) + NT_W'(ic_reg) + 1'b1) < nt_reg)
                down_next = 1'b1;
            else
            begin
                ib_next = '0;
                ic_next = ic_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gv_reg   <= 1'b0;
            ib_reg   <= '0;
            ic_reg   <= '0;
            down_reg <= 1'b0;
        end
        else
        begin
            gv_reg   <= gv_next;
            ib_reg   <= ib_next;
            ic_reg   <= ic_next;
            down_reg <= down_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            nt_reg <= NT_W'(subdiv_reg) + 1'b1;
            ax_reg <= ax;
            ay_reg <= ay;
            bx_reg <= bx;
            by_reg <= by;
            cx_reg <= cx;
            cy_reg <= cy;
            ac_reg <= a_color;
            bc_reg <= b_color;
            cc_reg <= c_color;
        end
    end

    // chip corners and color weights
    always_comb
    begin
        if (down_reg)
        begin
            pi[0] = NT_W'(ib_reg) + 1'b1;  pj[0] = NT_W'(ic_reg) + 1'b1;
            pi[1] = NT_W'(ib_reg);         pj[1] = NT_W'(ic_reg) + 1'b1;
            pi[2] = NT_W'(ib_reg) + 1'b1;  pj[2] = NT_W'(ic_reg);
        end
        else
        begin
            pi[0] = NT_W'(ib_reg);         pj[0] = NT_W'(ic_reg);
            pi[1] = NT_W'(ib_reg) + 1'b1;  pj[1] = NT_W'(ic_reg);
            pi[2] = NT_W'(ib_reg);         pj[2] = NT_W'(ic_reg) + 1'b1;
        end
        rcnt = 6'(nt_reg) - 6'(ib_reg) - 6'(ic_reg);
        wa   = WT_W'(6'd3 * rcnt - (down_reg ? 6'd4 : 6'd2));
        wb   = WT_W'(6'd3 * 6'(ib_reg) + (down_reg ? 6'd2 : 6'd1));
        wc   = WT_W'(6'd3 * 6'(ic_reg) + (down_reg ? 6'd2 : 6'd1));

        for (int k = 0; k < 3; k++)
        begin
            x1_next[2*k]     = lat_x(ax_reg, bx_reg, cx_reg, pi[k], pj[k], nt_reg);
            x1_next[2*k + 1] = lat_x(ay_reg, by_reg, cy_reg, pi[k], pj[k], nt_reg);
        end
        x1_next[6] = col_x(ac_reg[23:16], bc_reg[23:16], cc_reg[23:16], wa, wb, wc, nt_reg);
        x1_next[7] = col_x(ac_reg[15:8],  bc_reg[15:8],  cc_reg[15:8],  wa, wb, wc, nt_reg);
        x1_next[8] = col_x(ac_reg[7:0],   bc_reg[7:0],   cc_reg[7:0],   wa, wb, wc, nt_reg);
    end

    assign rdy3 = !v3_reg || out_ready;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                v1_reg <= gv_reg;
            if (rdy2)
                v2_reg <= v1_reg;
            if (rdy3)
                v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            x1_reg    <= x1_next;
            last1_reg <= chip_last;
            mco1_reg  <= coord_recip(nt_reg);
            mcl1_reg  <= color_recip(nt_reg);
            dco1_reg  <= DEN_W'({nt_reg, 1'b0});
            dcl1_reg  <= DEN_W'(nt_reg) * DEN_W'(6);
        end
        if (rdy2)
            last2_reg <= last1_reg;
        if (rdy3)
            last3_reg <= last2_reg;
    end

    assign dctl.ld_a = rdy2;
    assign dctl.ld_b = rdy3;

    for (genvar g = 0; g < LANES; g++)
    begin : g_lane
        tss_div u_div (
            .clk (clk),
            .ctl (dctl),
            .x   (x1_reg[g]),
            .m   ((g < COORD_LANES) ? mco1_reg : mcl1_reg),
            .d   ((g < COORD_LANES) ? dco1_reg : dcl1_reg),
            .q   (q[g])
        );
    end

    assign out_valid  = v3_reg;
    assign p0x        = q[0][COORD_W-1:0];
    assign p0y        = q[1][COORD_W-1:0];
    assign p1x        = q[2][COORD_W-1:0];
    assign p1y        = q[3][COORD_W-1:0];
    assign p2x        = q[4][COORD_W-1:0];
    assign p2y        = q[5][COORD_W-1:0];
    assign fill_red   = q[6][CHAN_W-1:0];
    assign fill_green = q[7][CHAN_W-1:0];
    assign fill_blue  = q[8][CHAN_W-1:0];
    assign last_chip  = last3_reg;

    a_accept_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && gv_reg) |-> (issue && chip_last))
        else $error("request taken while sequencer still has chips");

    a_last_is_up: assert property (@(posedge clk) disable iff (!rst_n)
        (gv_reg && chip_last) |-> (!down_reg && ib_reg == '0))
        else $error("last chip is not the apex up chip");

    a_down_legal: assert property (@(posedge clk) disable iff (!rst_n)
        (gv_reg && down_reg) |-> ((5'(ib_reg) + 5'(ic_reg) + 5'd2) <= 5'(nt_reg)))
        else $error("down chip outside triangle");

    a_nt_range: assert property (@(posedge clk) disable iff (!rst_n)
        gv_reg |-> (nt_reg != '0 && nt_reg <= NT_W'(NT_MAX)))
        else $error("interval count out of range");

endmodule

// ===== tb/sv/tss_chip_checker.sv =====
// Checker: tracks the subdivision register, predicts chips per triangle request, compares outputs.
module tss_chip_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [tss_pkg::SUB_W-1:0]           subdivisions,
    input  logic                                in_valid,
    input  logic                                in_ready,
    input  logic signed [tss_pkg::COORD_W-1:0]  ax,
    input  logic signed [tss_pkg::COORD_W-1:0]  ay,
    input  logic signed [tss_pkg::COORD_W-1:0]  bx,
    input  logic signed [tss_pkg::COORD_W-1:0]  by,
    input  logic signed [tss_pkg::COORD_W-1:0]  cx,
    input  logic signed [tss_pkg::COORD_W-1:0]  cy,
    input  logic [tss_pkg::COLOR_W-1:0]         a_color,
    input  logic [tss_pkg::COLOR_W-1:0]         b_color,
    input  logic [tss_pkg::COLOR_W-1:0]         c_color,
    input  logic                                out_valid,
    input  logic                                out_ready,
    input  logic signed [tss_pkg::COORD_W-1:0]  p0x,
    input  logic signed [tss_pkg::COORD_W-1:0]  p0y,
    input  logic signed [tss_pkg::COORD_W-1:0]  p1x,
    input  logic signed [tss_pkg::COORD_W-1:0]  p1y,
    input  logic signed [tss_pkg::COORD_W-1:0]  p2x,
    input  logic signed [tss_pkg::COORD_W-1:0]  p2y,
    input  logic [tss_pkg::CHAN_W-1:0]          fill_red,
    input  logic [tss_pkg::CHAN_W-1:0]          fill_green,
    input  logic [tss_pkg::CHAN_W-1:0]          fill_blue,
    input  logic                                last_chip,
    output int                                  fail_count,
    output int                                  pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import tss_pkg::*;

    typedef struct packed {
        logic signed [COORD_W-1:0] p0x;
        logic signed [COORD_W-1:0] p0y;
        logic signed [COORD_W-1:0] p1x;
        logic signed [COORD_W-1:0] p1y;
        logic signed [COORD_W-1:0] p2x;
        logic signed [COORD_W-1:0] p2y;
        logic [CHAN_W-1:0]         red;
        logic [CHAN_W-1:0]         green;
        logic [CHAN_W-1:0]         blue;
        logic                      last;
    } chip_t;

    chip_t             chip_q[$];
    chip_t             got;
    chip_t             want;
    logic [SUB_W-1:0]  subdiv_cur;
    int                err_cnt;

    // lattice point, rounded half up (floor of (2num+nt)/(2nt))
    function automatic logic signed [COORD_W-1:0] lattice_pt(
        input int a, input int b, input int c, input int i, input int j, input int nt);
        int num;
        int n2;
        int d2;
        int q;
        num = (nt - i - j) * a + i * b + j * c;
        n2  = 2 * num + nt;
        d2  = 2 * nt;
        q   = n2 / d2;
        if ((n2 % d2) != 0 && n2 < 0)
            q = q - 1;
        return q[COORD_W-1:0];
    endfunction

    function automatic logic [CHAN_W-1:0] shade_chan(
        input int ca, input int cb, input int cc,
        input int wa, input int wb, input int wc, input int den);
        int num;
        int q;
        num = wa * ca + wb * cb + wc * cc;
        q   = (2 * num + den) / (2 * den);
        return q[CHAN_W-1:0];
    endfunction

    task automatic split_triangle();
        int    nt;
        int    den;
        int    ib;
        int    ic;
        int    pass;
        int    i0, j0, i1, j1, i2, j2;
        int    wa, wb, wc;
        chip_t c;
        nt  = ((subdiv_cur > MAX_SUBDIV) ? MAX_SUBDIV : int'(subdiv_cur)) + 1;
        den = 3 * nt;
        for (ic = 0; ic < nt; ic++)
        begin
            for (ib = 0; ib < nt - ic; ib++)
            begin
                for (pass = 0; pass < 2; pass++)
                begin
                    if (pass == 1 && ib + ic + 2 > nt)
                        break;
                    if (pass == 0)
                    begin
                        i0 = ib;     j0 = ic;     i1 = ib + 1; j1 = ic;     i2 = ib;     j2 = ic + 1;
                        wa = 3 * (nt - ib - ic) - 2;
                        wb = 3 * ib + 1;
                        wc = 3 * ic + 1;
                    end
                    else
                    begin
                        i0 = ib + 1; j0 = ic + 1; i1 = ib;     j1 = ic + 1; i2 = ib + 1; j2 = ic;
                        wa = 3 * (nt - ib - ic) - 4;
                        wb = 3 * ib + 2;
                        wc = 3 * ic + 2;
                    end
                    c.p0x   = lattice_pt(int'(ax), int'(bx), int'(cx), i0, j0, nt);
                    c.p0y   = lattice_pt(int'(ay), int'(by), int'(cy), i0, j0, nt);
                    c.p1x   = lattice_pt(int'(ax), int'(bx), int'(cx), i1, j1, nt);
                    c.p1y   = lattice_pt(int'(ay), int'(by), int'(cy), i1, j1, nt);
                    c.p2x   = lattice_pt(int'(ax), int'(bx), int'(cx), i2, j2, nt);
                    c.p2y   = lattice_pt(int'(ay), int'(by), int'(cy), i2, j2, nt);
                    c.red   = shade_chan(int'(a_color[23:16]), int'(b_color[23:16]),
                                         int'(c_color[23:16]), wa, wb, wc, den);
                    c.green = shade_chan(int'(a_color[15:8]), int'(b_color[15:8]),
                                         int'(c_color[15:8]), wa, wb, wc, den);
                    c.blue  = shade_chan(int'(a_color[7:0]), int'(b_color[7:0]),
                                         int'(c_color[7:0]), wa, wb, wc, den);
                    c.last  = 1'b0;
                    chip_q.push_back(c);
                end
            end
        end
        c = chip_q.pop_back();
        c.last = 1'b1;
        chip_q.push_back(c);
    endtask

    task automatic check_field(input string field, input int want_v, input int got_v);
        if (want_v != got_v)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want_v, got_v);
            err_cnt++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            subdiv_cur = '0;
            chip_q.delete();
            err_cnt = 0;
            fail_count <= 0;
            pending <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                subdiv_cur = subdivisions;
            if (out_valid && out_ready)
            begin
                got = '{p0x, p0y, p1x, p1y, p2x, p2y, fill_red, fill_green, fill_blue, last_chip};
                if (chip_q.size() == 0)
                begin
                    $display("%0t: unexpected chip, expected none, actual %h", $time, got);
                    err_cnt++;
                end
                else
                begin
                    want = chip_q.pop_front();
                    check_field("p0x", int'(want.p0x), int'(got.p0x));
                    check_field("p0y", int'(want.p0y), int'(got.p0y));
                    check_field("p1x", int'(want.p1x), int'(got.p1x));
                    check_field("p1y", int'(want.p1y), int'(got.p1y));
                    check_field("p2x", int'(want.p2x), int'(got.p2x));
                    check_field("p2y", int'(want.p2y), int'(got.p2y));
                    check_field("fill_red", int'(want.red), int'(got.red));
                    check_field("fill_green", int'(want.green), int'(got.green));
                    check_field("fill_blue", int'(want.blue), int'(got.blue));
                    check_field("last_chip", int'(want.last), int'(got.last));
                end
            end
            if (in_valid && in_ready)
                split_triangle();
            fail_count <= err_cnt;
            pending <= chip_q.size();
        end
    end

endmodule

// ===== tb/sv/tb.sv =====
// Testbench top: clock, reset, triangle request stimulus, output stalls and verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import tss_pkg::*;

    localparam int QUIET_LIMIT = 4000;
    localparam int HOLD_CYCLES = 300;
    localparam int NPHASE      = 12;

    logic                       clk          = 1'b0;
    logic                       rst_n        = 1'b0;
    logic                       cfg_valid    = 1'b0;
    logic                       cfg_ready;
    logic [SUB_W-1:0]           subdivisions = '0;
    logic                       in_valid     = 1'b0;
    logic                       in_ready;
    logic signed [COORD_W-1:0]  ax = '0;
    logic signed [COORD_W-1:0]  ay = '0;
    logic signed [COORD_W-1:0]  bx = '0;
    logic signed [COORD_W-1:0]  by = '0;
    logic signed [COORD_W-1:0]  cx = '0;
    logic signed [COORD_W-1:0]  cy = '0;
    logic [COLOR_W-1:0]         a_color = '0;
    logic [COLOR_W-1:0]         b_color = '0;
    logic [COLOR_W-1:0]         c_color = '0;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic signed [COORD_W-1:0]  p0x, p0y, p1x, p1y, p2x, p2y;
    logic [CHAN_W-1:0]          fill_red, fill_green, fill_blue;
    logic                       last_chip;
    int                         fail_count;
    int                         pending;

    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    logic hold_go        = 1'b0;
    int   hold_left      = 0;
    int   quiet_cycles   = 0;

    int phase_sub[NPHASE] = '{0, 1, 2, 3, 7, 4, 5, 6, 0, 7, 1, 2};
    int phase_len[NPHASE] = '{20, 20, 25, 20, 4, 10, 8, 6, 21, 3, 20, 10};

    triangle_subdivision_shader uut (.*);
    tss_chip_checker chk (.*);

    always #5 clk = ~clk;

    // output side: random stalls plus one long hold-off
    always @(posedge clk)
    begin
        if (hold_go)
            hold_left = HOLD_CYCLES;
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (cfg_valid && cfg_ready) || (in_valid && in_ready)
            || (out_valid && out_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("triangle_subdivision_shader verification failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    function automatic logic signed [COORD_W-1:0] rand_coord();
        case ($urandom_range(7))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return '0;
            3:       return COORD_W'(int'($urandom_range(63)) - 32);
            default: return COORD_W'($urandom);
        endcase
    endfunction

    function automatic logic [CHAN_W-1:0] rand_chan();
        case ($urandom_range(5))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return CHAN_W'($urandom);
        endcase
    endfunction

    function automatic logic [COLOR_W-1:0] rand_color();
        return {rand_chan(), rand_chan(), rand_chan()};
    endfunction

    // one triangle request; valid stays up across back-to-back requests
    task automatic offer_tri(
        input logic signed [COORD_W-1:0] t_ax, input logic signed [COORD_W-1:0] t_ay,
        input logic signed [COORD_W-1:0] t_bx, input logic signed [COORD_W-1:0] t_by,
        input logic signed [COORD_W-1:0] t_cx, input logic signed [COORD_W-1:0] t_cy,
        input logic [COLOR_W-1:0] t_a, input logic [COLOR_W-1:0] t_b,
        input logic [COLOR_W-1:0] t_c);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        ax <= t_ax;
        ay <= t_ay;
        bx <= t_bx;
        by <= t_by;
        cx <= t_cx;
        cy <= t_cy;
        a_color <= t_a;
        b_color <= t_b;
        c_color <= t_c;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    task automatic write_subdiv(input int v);
        cfg_valid <= 1'b1;
        subdivisions <= SUB_W'(v);
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        int p;
        int k;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // register at its reset value: single average-colored chip
        offer_tri(0, 0, 0, 0, 0, 0, 24'h000000, 24'h000000, 24'h000000);
        offer_tri(-32768, -32768, 32767, 32767, 0, 0, 24'hFFFFFF, 24'h000000, 24'h000000);
        offer_tri(32767, 32767, 32767, 32767, 32767, 32767,
                  24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
        offer_tri(-1, -1, 1, -1, -1, 1, 24'h000001, 24'h000100, 24'h010000);
        offer_tri(100, -200, -300, 400, 5, 6, 24'h010203, 24'h0A0B0C, 24'hFF8001);
        drain();

        write_subdiv(7);
        offer_tri(-32768, 32767, 32767, -32768, -32768, -32768,
                  24'hFF0000, 24'h00FF00, 24'h0000FF);
        offer_tri(32767, 32767, -32768, 32767, 32767, -32768,
                  24'hFFFFFF, 24'h000000, 24'h808080);
        drain();

        // half-way ties on positive and negative coordinates, color ties
        write_subdiv(1);
        offer_tri(0, 0, 1, -1, -1, 1, 24'h000000, 24'h030303, 24'h000000);
        offer_tri(0, 0, 3, -3, -5, 5, 24'h000000, 24'h000000, 24'h030303);
        offer_tri(-32768, -32768, 32767, -32768, -32768, 32767,
                  24'hFFFFFF, 24'h000000, 24'hFFFFFF);
        drain();

        write_subdiv(2);
        offer_tri(0, 0, -1, 2, 1, -2, 24'h123456, 24'h789ABC, 24'hDEF012);
        offer_tri(-3, 3, 3, -3, 0, 1, 24'h0000FF, 24'h00FF00, 24'hFF0000);
        drain();

        write_subdiv(3);
        offer_tri(-32768, 0, 0, 32767, 32767, -32768, 24'h7F7F7F, 24'h808080, 24'h010101);
        drain();

        for (p = 0; p < NPHASE; p++)
        begin
            write_subdiv(phase_sub[p]);
            case (p % 4)
                0:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct <= 0;
                end
                1:
                begin
                    send_idle_pct = 60;
                    recv_stall_pct <= 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct <= 60;
                end
                default:
                begin
                    send_idle_pct = 16;
                    recv_stall_pct <= 16;
                end
            endcase
            if (p == 0)
            begin
                hold_go <= 1'b1;
                @(posedge clk);
                hold_go <= 1'b0;
            end
            for (k = 0; k < phase_len[p]; k++)
                offer_tri(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                          rand_coord(), rand_coord(), rand_color(), rand_color(),
                          rand_color());
            drain();
        end

        repeat (20) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("triangle_subdivision_shader verification clean");
        else
            $display("triangle_subdivision_shader verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/tss_pkg.sv
hw/rtl/tss_div.sv
hw/rtl/triangle_subdivision_shader.sv
tb/sv/tss_chip_checker.sv
tb/sv/tb.sv
